### design/tsb_pkg.sv
// ============================================================================
// tsb_pkg: shared types and constants for the tile sprite blitter
// Sequencer states, opcodes, register indexes and tile geometry.
// ============================================================================
package tsb_pkg;

    // tile geometry is fixed at 8x8
    localparam int TILE_SIZE = 8;
    localparam int TILE_BITS = 3;

    // framebuffer address width and color width
    localparam int FB_AW    = 18;
    localparam int COLOR_W  = 8;

    localparam logic [COLOR_W-1:0] TRANSPARENT = 8'hFF;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SCROLL_X = 2'd0;
    localparam logic [1:0] CFG_SCROLL_Y = 2'd1;
    localparam logic [1:0] CFG_SCREEN_W = 2'd2;
    localparam logic [1:0] CFG_SCREEN_H = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPLIT,
        ST_BASE,
        ST_REDUCE,
        ST_WALK,
        ST_DRAIN
    } t_state;

endpackage

### design/tile_sprite_blitter.sv
// ============================================================================
// tile_sprite_blitter: 8x8 tile blitter with palette lookup and mirroring
// Holds a square sheet of 2-bit color indexes, draws one tile per draw beat
// as a stream of framebuffer writes, clipped to the configured screen.
// ============================================================================
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+------------------------------
//  in      | into      | i_in_valid / o_in_stall | load one sheet entry or draw
//  out     | out of    | o_out_valid / i_out_stall | one visible pixel write
//  cfg     | into      | i_cfg_valid / o_cfg_ready | one register write
//
//  Load beats are taken back to back while idle. A draw beat holds the
//  input through capture, tile split and base setup, then the walk over the
//  tile's 64 pixels, one sheet read per cycle through the single read port
//  while the output is not stalled, then the drain. When the tile base can
//  run past the end of the sheet, a reduce step brings it modulo the sheet
//  depth by reciprocal multiply (never needed at the default sizes).
//  Output stalls freeze the walk; the sheet read data is held in place.
//  Reset (synchronous, active low) clears control and config; the sheet
//  itself is not cleared and must be loaded before it is drawn.
//
module tile_sprite_blitter
    import tsb_pkg::*;
#(
    parameter int SHEET_SIZE    = 256,
    parameter int TILES_PER_ROW = 32,
    parameter int MAX_SCREEN    = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [15:0]          i_sheet_address,
    input  logic [1:0]           i_sheet_index,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic [9:0]           i_tile_number,
    input  logic [31:0]          i_packed_colors,
    input  logic [1:0]           i_mirror_flags,

    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FB_AW-1:0]     o_pixel_address,
    output logic [COLOR_W-1:0]   o_pixel_color,
    output logic                 o_last,

    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int DEPTH    = SHEET_SIZE * SHEET_SIZE;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = (TILES_PER_ROW > 1) ? $clog2(TILES_PER_ROW) : 1;
    // reciprocal for tile / TILES_PER_ROW; at most one short for 10-bit tiles
    localparam int RECIP    = (1 << 20) / TILES_PER_ROW;
    localparam int BASE_MAX = (TILES_PER_ROW - 1) * TILE_SIZE
                            + (1023 / TILES_PER_ROW) * TILE_SIZE * SHEET_SIZE;
    localparam int BW       = $clog2(BASE_MAX + 1);
    localparam bit NEED_RED = (BASE_MAX >= DEPTH);
    // base / DEPTH by reciprocal; 2^BW exceeds any base, so at most one short
    localparam int QW       = (BW > AW) ? BW - AW + 1 : 1;
    localparam int RECIP_D  = (1 << BW) / DEPTH;
    localparam int XW       = (BW > AW) ? BW : AW + 1;
    localparam int CNW      = 2;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic signed [15:0] r_scroll_x, r_scroll_y;
    logic [9:0]         r_width, r_height;

    function automatic logic [9:0] clamp_screen(input logic [9:0] v);
        if (32'(v) > 32'(MAX_SCREEN)) begin
            clamp_screen = 10'(MAX_SCREEN);
        end else begin
            clamp_screen = v;
        end
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_width    <= clamp_screen(10'd160);
            r_height   <= clamp_screen(10'd120);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCROLL_X: r_scroll_x <= i_cfg_data;
                CFG_SCROLL_Y: r_scroll_y <= i_cfg_data;
                CFG_SCREEN_W: r_width    <= clamp_screen(i_cfg_data[9:0]);
                CFG_SCREEN_H: r_height   <= clamp_screen(i_cfg_data[9:0]);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic in_accept, load_wr, draw_start;
    logic advance;       // output side can take a pipeline step
    logic walk_step;     // walker issues one pixel this cycle
    logic drain_step;    // drain stage moves this cycle
    logic finish;        // draw ends, pending pixel leaves as last

    logic [TILE_BITS-1:0] r_x, r_y;
    logic [CNW-1:0]       r_cnt;
    logic                 pix_final;
    logic                 red_done;

    logic r_o_valid, r_s1_valid, r_p_valid;

    assign pix_final = (r_x == TILE_BITS'(TILE_SIZE - 1))
                    && (r_y == TILE_BITS'(TILE_SIZE - 1));
    assign red_done  = (r_cnt == CNW'(2));
    assign advance   = !r_o_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_accept && i_op == OP_DRAW) n_state = ST_DIV;
            ST_DIV:    n_state = ST_SPLIT;
            ST_SPLIT:  n_state = ST_BASE;
            ST_BASE:   n_state = NEED_RED ? ST_REDUCE : ST_WALK;
            ST_REDUCE: if (red_done) n_state = ST_WALK;
            ST_WALK:   if (advance && pix_final) n_state = ST_DRAIN;
            ST_DRAIN:  if (advance && !r_s1_valid) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        in_accept  = i_in_valid && !o_in_stall;
        load_wr    = in_accept && (i_op == OP_LOAD)
                  && (32'(i_sheet_address) < 32'(DEPTH));
        draw_start = in_accept && (i_op == OP_DRAW);
        walk_step  = (r_state == ST_WALK) && advance;
        drain_step = (r_state == ST_DRAIN) && advance;
        finish     = drain_step && !r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Draw setup: capture, tile split, base address, base mod sheet depth
    // ------------------------------------------------------------------
    logic signed [16:0] r_sx0, r_sy0;
    logic [9:0]         r_tile;
    logic [31:0]        r_colors;
    logic [1:0]         r_mirror;
    logic [9:0]         r_q0, r_trow;
    logic [CW-1:0]      r_tcol;
    logic [BW-1:0]      r_base;
    logic [AW-1:0]      r_rem;
    logic [QW-1:0]      r_red_q;
    logic [AW:0]        r_red;

    logic [30:0] div_prod;
    logic [17:0] split_rem;
    logic [BW-1:0] base_lin;
    logic [BW+QW-1:0] red_prod;
    logic [XW-1:0]    red_diff;

    assign div_prod  = 31'(r_tile) * 31'(RECIP);
    assign split_rem = 18'(r_tile) - 18'(r_q0) * 18'(TILES_PER_ROW);
    assign base_lin  = BW'(r_tcol) * BW'(TILE_SIZE)
                     + BW'(r_trow) * BW'(TILE_SIZE * SHEET_SIZE);
    assign red_prod  = (BW+QW)'(r_base) * (BW+QW)'(RECIP_D);
    assign red_diff  = XW'(r_base) - XW'(r_red_q) * XW'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (draw_start) begin
            r_sx0    <= 17'(i_pos_x) - 17'(r_scroll_x);
            r_sy0    <= 17'(i_pos_y) - 17'(r_scroll_y);
            r_tile   <= i_tile_number;
            r_colors <= i_packed_colors;
            r_mirror <= i_mirror_flags;
        end
        if (r_state == ST_DIV) begin
            r_q0 <= div_prod[29:20];
        end
        if (r_state == ST_SPLIT) begin
            // reciprocal quotient may be one short
            if (split_rem >= 18'(TILES_PER_ROW)) begin
                r_tcol <= CW'(split_rem - 18'(TILES_PER_ROW));
                r_trow <= r_q0 + 10'd1;
            end else begin
                r_tcol <= CW'(split_rem);
                r_trow <= r_q0;
            end
        end
        if (r_state == ST_BASE) begin
            r_base <= base_lin;
            r_rem  <= NEED_RED ? '0 : AW'(base_lin);
            r_cnt  <= '0;
        end
        if (r_state == ST_REDUCE) begin
            // quotient estimate, partial remainder, then one correction
            if (r_cnt == CNW'(0)) begin
                r_red_q <= QW'(red_prod >> BW);
            end else if (r_cnt == CNW'(1)) begin
                r_red <= (AW+1)'(red_diff);
            end else if (r_red >= (AW+1)'(DEPTH)) begin
                r_rem <= AW'(r_red - (AW+1)'(DEPTH));
            end else begin
                r_rem <= AW'(r_red);
            end
            r_cnt <= r_cnt + CNW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Tile walker (stage 0): sheet address, clip and screen address
    // ------------------------------------------------------------------
    logic [TILE_BITS-1:0] xs, ys;
    logic [AW:0]          rd_sum;
    logic [AW-1:0]        rd_addr;
    logic signed [17:0]   sx, sy;
    logic                 vis_xy;
    logic [FB_AW-1:0]     pix_addr;

    always_comb begin
        xs     = r_x ^ {TILE_BITS{r_mirror[0]}};
        ys     = r_y ^ {TILE_BITS{r_mirror[1]}};
        // offset stays below the depth, so one subtract wraps it
        rd_sum = {1'b0, r_rem} + (AW+1)'(xs)
               + (AW+1)'(ys) * (AW+1)'(SHEET_SIZE);
        if (rd_sum >= (AW+1)'(DEPTH)) begin
            rd_addr = AW'(rd_sum - (AW+1)'(DEPTH));
        end else begin
            rd_addr = AW'(rd_sum);
        end
        sx       = 18'(r_sx0) + 18'(r_x);
        sy       = 18'(r_sy0) + 18'(r_y);
        vis_xy   = !sx[17] && (sx[16:0] < 17'(r_width))
                && !sy[17] && (sy[16:0] < 17'(r_height));
        pix_addr = FB_AW'(20'(sx[9:0]) + 20'(sy[9:0]) * 20'(r_width));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_BASE) begin
            r_x <= '0;
            r_y <= '0;
        end else if (walk_step) begin
            r_x <= r_x + TILE_BITS'(1);
            if (r_x == TILE_BITS'(TILE_SIZE - 1)) begin
                r_y <= r_y + TILE_BITS'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sheet memory: one write port for loads, one registered read port.
    // Loads only land while idle, so reads and writes never overlap.
    // ------------------------------------------------------------------
    logic [1:0] mem [DEPTH];
    logic [1:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            mem[AW'(i_sheet_address)] <= i_sheet_index;
        end
        if (walk_step) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 sidecar, pending pixel and output register.
    // The pending pixel waits until a later visible pixel or the end of
    // the draw tells whether it is the last write.
    // ------------------------------------------------------------------
    logic             r_s1_vis;
    logic [FB_AW-1:0] r_s1_pa;
    logic [FB_AW-1:0] r_p_pa, r_o_pa;
    logic [COLOR_W-1:0] r_p_color, r_o_color;
    logic             r_o_last;
    logic [COLOR_W-1:0] s1_color;
    logic             s1_show;

    assign s1_color = r_colors[8*r_mem_q +: 8];
    assign s1_show  = r_s1_valid && r_s1_vis && (s1_color != TRANSPARENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_p_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= walk_step;
            r_o_valid  <= 1'b0;
            if (s1_show) begin
                r_p_valid <= 1'b1;
                r_o_valid <= r_p_valid;
            end else if (finish) begin
                r_p_valid <= 1'b0;
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_step) begin
            r_s1_vis <= vis_xy;
            r_s1_pa  <= pix_addr;
        end
        if (advance) begin
            if (s1_show) begin
                r_p_pa    <= r_s1_pa;
                r_p_color <= s1_color;
                r_o_pa    <= r_p_pa;
                r_o_color <= r_p_color;
                r_o_last  <= 1'b0;
            end else if (finish) begin
                r_o_pa    <= r_p_pa;
                r_o_color <= r_p_color;
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_pixel_address = r_o_pa;
    assign o_pixel_color   = r_o_color;
    assign o_last          = r_o_last;

`ifndef SYNTH
    // stage 1 only carries pixels of a draw in progress
    a_s1_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == ST_WALK || r_state == ST_DRAIN))
        else $error("stage 1 valid outside tile walk");

    // a last write leaves nothing pending behind it
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> !r_p_valid)
        else $error("pixel pending behind last write");

    // reduced sheet base stays inside the sheet during the walk
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ((AW+1)'(r_rem) < (AW+1)'(DEPTH)))
        else $error("sheet base out of range");

    // the walk always ends in the drain
    a_walk_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk_step && pix_final) |=> (r_state == ST_DRAIN && r_s1_valid))
        else $error("final tile pixel not followed by drain");
`endif

endmodule
